// ===== hw/rtl/smx_pkg.sv =====
// Shared types, codes and constants of the stack machine executor.
package smx_pkg;

  localparam int SMX_STACK_DEPTH = 64;
  localparam int SMX_MEM_WORDS   = 128;
  localparam int WORD_W          = 64;
  localparam int HALF_W          = WORD_W / 2;
  localparam int ADDR_W          = 7;
  localparam int MD_CNT_W        = 6;
  localparam logic [MD_CNT_W-1:0] DIV_LAST = MD_CNT_W'(WORD_W - 1);
  localparam logic [MD_CNT_W-1:0] MUL_LAST = MD_CNT_W'(3);

  typedef enum logic [2:0] {
    FN_PUSH_IMM = 3'd0,
    FN_PUSH_MEM = 3'd1,
    FN_POP      = 3'd2,
    FN_ADD      = 3'd3,
    FN_SUB      = 3'd4,
    FN_MUL      = 3'd5,
    FN_DIV      = 3'd6,
    FN_PRINT    = 3'd7
  } func_t;

  typedef enum logic [2:0] {
    KD_DONE  = 3'd0,
    KD_PRINT = 3'd1,
    KD_UNDER = 3'd2,
    KD_OVER  = 3'd3,
    KD_DIVZ  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_READ_A,
    ST_ARITH
  } st_t;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] immediate;
    logic [ADDR_W-1:0]  address;
  } instr_t;

  typedef struct packed {
    logic [2:0]               kind;
    logic signed [WORD_W-1:0] value;
  } result_t;

  typedef struct packed {
    logic  clr_step;
    logic  latch;
    logic  rd_second;
    logic  cap_b;
    logic  md_start;
    logic  do_push;
    logic  do_pop;
    logic  do_bin;
    logic  finish;
    kind_t kind;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  sp_empty;
    logic  sp_lt2;
    logic  sp_full;
    logic  b_zero;
    logic  md_done;
    logic  res_free;
    logic  clr_last;
  } stat_t;

endpackage

// ===== hw/rtl/smx_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module smx_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/smx_md.sv =====
// Multi-cycle multiply and divide unit for 64-bit wrapping signed arithmetic.
module smx_md
  import smx_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              op_div,
  input  logic [WORD_W-1:0] a,
  input  logic [WORD_W-1:0] b,
  output logic              done,
  output logic [WORD_W-1:0] res
);

  logic                busy;
  logic                is_div;
  logic [MD_CNT_W-1:0] cnt;
  logic                last;

  logic [WORD_W-1:0] a_q;
  logic [WORD_W-1:0] b_q;
  logic [WORD_W-1:0] preg;
  logic [WORD_W-1:0] acc;
  logic [HALF_W-1:0] mul_x;
  logic [HALF_W-1:0] mul_y;

  logic [WORD_W-1:0] quo;
  logic [WORD_W-1:0] rem;
  logic [WORD_W-1:0] dvsr;
  logic              neg;
  logic [WORD_W:0]   shifted;
  logic              fits;

  function automatic logic [WORD_W-1:0] mag(input logic [WORD_W-1:0] x);
    mag = x[WORD_W-1] ? (~x + WORD_W'(1)) : x;
  endfunction

  assign last    = is_div ? (cnt == DIV_LAST) : (cnt == MUL_LAST);
  assign mul_x   = (cnt == MD_CNT_W'(2)) ? a_q[WORD_W-1:HALF_W] : a_q[HALF_W-1:0];
  assign mul_y   = (cnt == MD_CNT_W'(1)) ? b_q[WORD_W-1:HALF_W] : b_q[HALF_W-1:0];
  assign shifted = {rem, quo[WORD_W-1]};
  assign fits    = shifted >= {1'b0, dvsr};
  assign res     = is_div ? (neg ? (~quo + WORD_W'(1)) : quo) : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + MD_CNT_W'(1);
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      is_div <= op_div;
      a_q    <= a;
      b_q    <= b;
      quo    <= mag(a);
      dvsr   <= mag(b);
      rem    <= '0;
      neg    <= a[WORD_W-1] ^ b[WORD_W-1];
      acc    <= '0;
    end else if (busy) begin
      if (is_div) begin
        // Restoring division on magnitudes, one quotient bit per cycle.
        if (fits) begin
          rem <= WORD_W'(shifted - {1'b0, dvsr});
        end else begin
          rem <= shifted[WORD_W-1:0];
        end
        quo <= {quo[WORD_W-2:0], fits};
      end else begin
        // Low word of the product from three half-width partial products.
        preg <= mul_x * mul_y;
        if (cnt == MD_CNT_W'(1)) begin
          acc <= preg;
        end else if (cnt != MD_CNT_W'(0)) begin
          acc <= acc + {preg[HALF_W-1:0], {HALF_W{1'b0}}};
        end
      end
    end
  end

endmodule

// ===== hw/rtl/smx_dpath.sv =====
// Datapath: operand stack, data memory, arithmetic and the result stages.
module smx_dpath
  import smx_pkg::*;
#(
  parameter int STACK_DEPTH = SMX_STACK_DEPTH,
  parameter int MEM_WORDS   = SMX_MEM_WORDS
) (
  input  logic    clk,
  input  logic    rst,
  input  cmd_t    cmd,
  output stat_t   stat,
  input  instr_t  instr,
  input  logic    result_stall,
  output logic    result_valid,
  output result_t result
);

  localparam int SAW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SP_W   = $clog2(STACK_DEPTH + 1);
  localparam int MEM_AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int MCW    = ((MEM_AW > ADDR_W) ? MEM_AW : ADDR_W) + 1;

  instr_t            instr_q;
  func_t             func;
  logic [SP_W-1:0]   sp;
  logic [SP_W-1:0]   sp_m1;
  logic [SP_W-1:0]   sp_m2;
  logic [WORD_W-1:0] b_reg;

  logic [MCW-1:0]    rd_addr_w;
  logic [MCW-1:0]    q_addr_w;
  logic              in_range;
  logic [MEM_AW-1:0] clr_idx;

  logic              stk_we;
  logic [SAW-1:0]    stk_waddr;
  logic [WORD_W-1:0] stk_wdata;
  logic [SAW-1:0]    stk_raddr;
  logic [WORD_W-1:0] stk_rdata;

  logic              mem_we;
  logic [MEM_AW-1:0] mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [WORD_W-1:0] mem_rdata;

  logic [WORD_W-1:0] push_word;
  logic [WORD_W-1:0] bin_result;
  logic              md_done;
  logic [WORD_W-1:0] md_res;

  logic    res_valid;
  result_t res;
  logic    res_move;

  assign func      = func_t'(instr_q.func);
  assign sp_m1     = sp - SP_W'(1);
  assign sp_m2     = sp - SP_W'(2);
  assign rd_addr_w = MCW'(instr.address);
  assign q_addr_w  = MCW'(instr_q.address);
  assign in_range  = q_addr_w < MCW'(MEM_WORDS);

  assign push_word = (func == FN_PUSH_MEM) ? (in_range ? mem_rdata : '0)
                                           : {{HALF_W{instr_q.immediate[31]}},
                                              instr_q.immediate};

  always_comb begin
    case (func)
      FN_ADD:  bin_result = stk_rdata + b_reg;
      FN_SUB:  bin_result = stk_rdata - b_reg;
      default: bin_result = md_res;
    endcase
  end

  // The read port tracks the top of stack unless the second operand is wanted.
  assign stk_raddr = cmd.rd_second ? sp_m2[SAW-1:0] : sp_m1[SAW-1:0];
  assign stk_we    = cmd.do_push | cmd.do_bin;
  assign stk_waddr = cmd.do_push ? sp[SAW-1:0] : sp_m2[SAW-1:0];
  assign stk_wdata = cmd.do_push ? push_word : bin_result;

  assign mem_we    = cmd.clr_step | (cmd.do_pop & (func == FN_POP) & in_range);
  assign mem_waddr = cmd.clr_step ? clr_idx : q_addr_w[MEM_AW-1:0];
  assign mem_wdata = cmd.clr_step ? '0 : stk_rdata;

  smx_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  smx_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MEM_WORDS)
  ) u_dmem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rd_addr_w[MEM_AW-1:0]),
    .rdata (mem_rdata)
  );

  smx_md u_md (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.md_start),
    .op_div (func == FN_DIV),
    .a      (stk_rdata),
    .b      (b_reg),
    .done   (md_done),
    .res    (md_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sp      <= '0;
      clr_idx <= '0;
    end else begin
      if (cmd.clr_step) begin
        clr_idx <= clr_idx + MEM_AW'(1);
      end
      if (cmd.do_push) begin
        sp <= sp + SP_W'(1);
      end else if (cmd.do_pop | cmd.do_bin) begin
        sp <= sp_m1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      instr_q <= instr;
    end
    if (cmd.cap_b) begin
      b_reg <= stk_rdata;
    end
  end

  // Two result slots let a new transaction start while one result waits.
  assign res_move = res_valid & (~result_valid | ~result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        res_valid <= 1'b1;
      end else if (res_move) begin
        res_valid <= 1'b0;
      end
      if (res_move) begin
        result_valid <= 1'b1;
      end else if (~result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res.kind  <= cmd.kind;
      res.value <= (cmd.kind == KD_PRINT) ? stk_rdata : '0;
    end
    if (res_move) begin
      result <= res;
    end
  end

  assign stat.func     = func;
  assign stat.sp_empty = sp == '0;
  assign stat.sp_lt2   = sp < SP_W'(2);
  assign stat.sp_full  = sp == SP_W'(STACK_DEPTH);
  assign stat.b_zero   = b_reg == '0;
  assign stat.md_done  = md_done;
  assign stat.res_free = ~res_valid | res_move;
  assign stat.clr_last = clr_idx == MEM_AW'(MEM_WORDS - 1);

endmodule

// ===== hw/rtl/smx_ctrl.sv =====
// Controller state machine that sequences each instruction through the datapath.
module smx_ctrl
  import smx_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  instr_valid,
  output logic  instr_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  st_t state;
  st_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.kind    = KD_DONE;
    instr_stall = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        instr_stall = ~stat.res_free;
        if (instr_valid && stat.res_free) begin
          cmd.latch  = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
        unique case (stat.func) inside
          FN_PUSH_IMM, FN_PUSH_MEM: begin
            cmd.finish = 1'b1;
            if (stat.sp_full) begin
              cmd.kind = KD_OVER;
            end else begin
              cmd.do_push = 1'b1;
            end
          end
          FN_POP, FN_PRINT: begin
            cmd.finish = 1'b1;
            if (stat.sp_empty) begin
              cmd.kind = KD_UNDER;
            end else begin
              cmd.do_pop = 1'b1;
              cmd.kind   = (stat.func == FN_PRINT) ? KD_PRINT : KD_DONE;
            end
          end
          default: begin
            if (stat.sp_lt2) begin
              cmd.finish = 1'b1;
              cmd.kind   = KD_UNDER;
            end else begin
              cmd.cap_b     = 1'b1;
              cmd.rd_second = 1'b1;
              state_next    = ST_READ_A;
            end
          end
        endcase
      end
      ST_READ_A: begin
        unique case (stat.func) inside
          FN_ADD, FN_SUB: begin
            cmd.do_bin = 1'b1;
            cmd.finish = 1'b1;
            state_next = ST_IDLE;
          end
          FN_DIV: begin
            if (stat.b_zero) begin
              cmd.finish = 1'b1;
              cmd.kind   = KD_DIVZ;
              state_next = ST_IDLE;
            end else begin
              cmd.md_start = 1'b1;
              state_next   = ST_ARITH;
            end
          end
          default: begin
            cmd.md_start = 1'b1;
            state_next   = ST_ARITH;
          end
        endcase
      end
      ST_ARITH: begin
        if (stat.md_done) begin
          cmd.do_bin = 1'b1;
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/stack_machine_executor.sv =====
// Top level of the stack machine executor: controller plus datapath.
//
// Each instruction transaction yields exactly one result transaction. After
// reset the data memory is cleared one word per cycle, and the block stalls
// instructions until the last word is cleared. Multiply forms three 32x32
// partial products in the multiply unit, divide takes one quotient bit per
// cycle in the divide unit, and a divide by zero is found before that unit
// starts. The single read port of the operand stack fetches the two operands
// of a binary operation in turn. A result may wait at the output while the
// next instruction runs; a second pending result stalls the input.
module stack_machine_executor
  import smx_pkg::*;
#(
  parameter int STACK_DEPTH = SMX_STACK_DEPTH,
  parameter int MEM_WORDS   = SMX_MEM_WORDS
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    instr_valid,
  output logic    instr_stall,
  input  instr_t  instr,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  cmd_t  cmd;
  stat_t stat;

  smx_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .instr_valid (instr_valid),
    .instr_stall (instr_stall),
    .stat        (stat),
    .cmd         (cmd)
  );

  smx_dpath #(
    .STACK_DEPTH (STACK_DEPTH),
    .MEM_WORDS   (MEM_WORDS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .instr        (instr),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule
